### sv/budgeted_snapshot_retention_assert.svh
// Assertion macros for the snapshot retention block, clocked on clk, reset by arst_n.
`ifndef BUDGETED_SNAPSHOT_RETENTION_ASSERT_SVH
`define BUDGETED_SNAPSHOT_RETENTION_ASSERT_SVH
`ifndef SYNTHESIS
// Condition holds whenever the antecedent holds in the same cycle.
`define BSR_ASSERT_SAME(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
	else $error("bsr check failed");
// Condition holds in the cycle after the antecedent.
`define BSR_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
	else $error("bsr check failed");
`else
`define BSR_ASSERT_SAME(lbl, pre, post)
`define BSR_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

### sv/bsr_pkg.sv
// Shared constants, codes and types of the snapshot retention block.
package bsr_pkg;
	localparam int SLOTS = 16;
	localparam int IDX_W = $clog2(SLOTS);
	localparam int CNT_W = $clog2(SLOTS + 1);

	typedef enum logic [1:0] {
		OP_CAPTURE = 2'd0,
		OP_BUDGET  = 2'd1,
		OP_REMOVE  = 2'd2,
		OP_CLEAR   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_TOO_LARGE = 3'd1,
		ST_CKPT_KEPT = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_FULL      = 3'd4
	} status_t;

	// Table commands from the sequencer
	typedef struct packed {
		logic             erase;
		logic [IDX_W-1:0] erase_idx;
		logic             write;
		logic [IDX_W-1:0] write_idx;
		logic             kind;
		logic [31:0]      size;
		logic [31:0]      ident;
	} tbl_cmd_t;

	// Entry seen at the scan index
	typedef struct packed {
		logic        kind;
		logic [31:0] size;
		logic [31:0] ident;
	} tbl_rd_t;
endpackage

### sv/bsr_table.sv
// Age-ordered entry table: compacting erase, append write, one scan read port.
module bsr_table (
	input  logic                           clk,
	input  bsr_pkg::tbl_cmd_t              cmd,
	input  logic [bsr_pkg::IDX_W-1:0]      rd_idx,
	output bsr_pkg::tbl_rd_t               rd
);
	logic        kind_q  [bsr_pkg::SLOTS];
	logic [31:0] size_q  [bsr_pkg::SLOTS];
	logic [31:0] ident_q [bsr_pkg::SLOTS];

	// Erase shifts every entry above the erased one down by one place
	always_ff @(posedge clk) begin
		for (int i = 0; i < bsr_pkg::SLOTS; i++) begin
			if (cmd.erase && (i >= int'(cmd.erase_idx)) && (i + 1 < bsr_pkg::SLOTS)) begin
				kind_q[i]  <= kind_q[i+1];
				size_q[i]  <= size_q[i+1];
				ident_q[i] <= ident_q[i+1];
			end else if (cmd.write && (i == int'(cmd.write_idx))) begin
				kind_q[i]  <= cmd.kind;
				size_q[i]  <= cmd.size;
				ident_q[i] <= cmd.ident;
			end
		end
	end

	assign rd.kind  = kind_q[rd_idx];
	assign rd.size  = size_q[rd_idx];
	assign rd.ident = ident_q[rd_idx];
endmodule

### sv/budgeted_snapshot_retention.sv
// Clear and a too-large capture go straight to the result; a checkpoint capture or a budget
// change first checks usage against the budget; a remove scans entries for the id; an automatic
// capture adds a summing pass over live entries, and each eviction a forward search and an erase.
// Throughput: one operation at a time, ready again in the cycle its result goes valid; a result
// not yet taken holds the block. Reset: clears fill count, usage and budget, next id is one.
`include "budgeted_snapshot_retention_assert.svh"
module budgeted_snapshot_retention (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [95:0]  s_tdata,  // byte_count[31:0], new_budget[63:32], target_id[95:64]
	input  logic [2:0]   s_tuser,  // op[1:0], kind[2]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [71:0]  m_tdata,  // new_id[31:0], evicted_count[36:32], used_total[68:37]
	output logic [3:0]   m_tuser   // ok[0], status[3:1]
);
	typedef enum logic [2:0] {
		S_IDLE, S_SUM, S_FEAS, S_CHECK, S_FIND, S_ERASE, S_DONE
	} state_t;

	state_t                      state_q;
	bsr_pkg::op_t                op_q;
	logic                        kind_q;
	logic [31:0]                 bytes_q, target_q;
	logic [31:0]                 used_q, budget_q, next_id_q;
	logic [bsr_pkg::CNT_W-1:0]   count_q, scan_q;
	logic [32:0]                 reclaim_q;
	logic                        no_auto_q;
	logic                        ok_q;
	bsr_pkg::status_t            status_q;
	logic [31:0]                 new_id_q;
	logic [4:0]                  evicted_q;
	logic                        mv_q;
	logic [3:0]                  mu_q;
	logic [71:0]                 md_q;

	bsr_pkg::tbl_cmd_t           cmd;
	bsr_pkg::tbl_rd_t            rd;
	logic [32:0]                 need;
	logic                        over, at_end, full, cap, auto_only;
	logic [33:0]                 feas_lhs, feas_rhs;
	bsr_pkg::op_t                in_op;

	assign in_op     = bsr_pkg::op_t'(s_tuser[1:0]);
	assign s_tready  = (state_q == S_IDLE);
	assign m_tvalid  = mv_q;
	assign m_tdata   = md_q;
	assign m_tuser   = mu_q;

	// Shared add/compare unit: usage (plus capture size) against the budget
	assign cap       = (op_q == bsr_pkg::OP_CAPTURE);
	assign auto_only = cap && !kind_q;
	assign need      = {1'b0, used_q} + (cap ? {1'b0, bytes_q} : 33'd0);
	assign over      = need > {1'b0, budget_q};
	assign at_end    = (scan_q == count_q);
	assign full      = (count_q == bsr_pkg::CNT_W'(bsr_pkg::SLOTS));
	assign feas_lhs  = {2'b0, used_q} + {2'b0, bytes_q};
	assign feas_rhs  = {2'b0, budget_q} + {1'b0, reclaim_q};

	// Table control
	always_comb begin
		cmd           = '0;
		cmd.erase     = (state_q == S_ERASE);
		cmd.erase_idx = scan_q[bsr_pkg::IDX_W-1:0];
		cmd.write     = (state_q == S_CHECK) && cap && !over && !full;
		cmd.write_idx = count_q[bsr_pkg::IDX_W-1:0];
		cmd.kind      = kind_q;
		cmd.size      = bytes_q;
		cmd.ident     = next_id_q;
	end

	bsr_table u_table (
		.clk    (clk),
		.cmd    (cmd),
		.rd_idx (scan_q[bsr_pkg::IDX_W-1:0]),
		.rd     (rd)
	);

	// Sequencer and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			used_q    <= '0;
			budget_q  <= '0;
			next_id_q <= 32'd1;
			count_q   <= '0;
			mv_q      <= 1'b0;
		end else begin
			if (mv_q && m_tready && (state_q != S_DONE))
				mv_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						op_q      <= in_op;
						kind_q    <= s_tuser[2];
						bytes_q   <= s_tdata[31:0];
						target_q  <= s_tdata[95:64];
						ok_q      <= 1'b0;
						status_q  <= bsr_pkg::ST_OK;
						new_id_q  <= '0;
						evicted_q <= '0;
						scan_q    <= '0;
						reclaim_q <= '0;
						no_auto_q <= 1'b0;
						unique case (in_op)
							bsr_pkg::OP_CAPTURE: begin
								if (s_tdata[31:0] > budget_q) begin
									status_q <= bsr_pkg::ST_TOO_LARGE;
									state_q  <= S_DONE;
								end else if (!s_tuser[2]) begin
									state_q <= S_SUM;
								end else begin
									state_q <= S_CHECK;
								end
							end
							bsr_pkg::OP_BUDGET: begin
								budget_q <= s_tdata[63:32];
								state_q  <= S_CHECK;
							end
							bsr_pkg::OP_REMOVE: state_q <= S_FIND;
							bsr_pkg::OP_CLEAR: begin
								count_q <= '0;
								used_q  <= '0;
								state_q <= S_DONE;
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				// Total of automatic entries
				S_SUM: begin
					if (at_end) begin
						scan_q  <= '0;
						state_q <= S_FEAS;
					end else begin
						if (!rd.kind)
							reclaim_q <= reclaim_q + {1'b0, rd.size};
						scan_q <= scan_q + 1'b1;
					end
				end
				S_FEAS: begin
					if (feas_lhs > feas_rhs) begin
						status_q <= bsr_pkg::ST_CKPT_KEPT;
						state_q  <= S_DONE;
					end else begin
						state_q <= S_CHECK;
					end
				end
				// Decide: evict another entry, append, or finish
				S_CHECK: begin
					if (over || (cap && full)) begin
						if (!no_auto_q) begin
							state_q <= S_FIND;
						end else if (auto_only || count_q == '0) begin
							if (cap)
								status_q <= over ? bsr_pkg::ST_CKPT_KEPT : bsr_pkg::ST_FULL;
							state_q <= S_DONE;
						end else begin
							scan_q  <= '0;
							state_q <= S_ERASE;
						end
					end else if (cap) begin
						count_q   <= count_q + 1'b1;
						used_q    <= used_q + bytes_q;
						new_id_q  <= next_id_q;
						next_id_q <= (next_id_q == '1) ? 32'd1 : next_id_q + 32'd1;
						ok_q      <= 1'b1;
						state_q   <= S_DONE;
					end else begin
						state_q <= S_DONE;
					end
				end
				// Scan for oldest automatic entry, or the id to remove
				S_FIND: begin
					if (at_end) begin
						if (op_q == bsr_pkg::OP_REMOVE) begin
							status_q <= bsr_pkg::ST_NOT_FOUND;
							state_q  <= S_DONE;
						end else begin
							no_auto_q <= 1'b1;
							state_q   <= S_CHECK;
						end
					end else if ((op_q == bsr_pkg::OP_REMOVE) ? (rd.ident == target_q)
						: !rd.kind) begin
						state_q <= S_ERASE;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				S_ERASE: begin
					used_q  <= used_q - rd.size;
					count_q <= count_q - 1'b1;
					if (op_q == bsr_pkg::OP_REMOVE) begin
						ok_q    <= 1'b1;
						state_q <= S_DONE;
					end else begin
						if (evicted_q != '1)
							evicted_q <= evicted_q + 5'd1;
						state_q <= S_CHECK;
					end
				end
				S_DONE: begin
					if (!mv_q || m_tready) begin
						mv_q    <= 1'b1;
						mu_q    <= {status_q, ok_q};
						md_q    <= {3'b0, used_q, evicted_q, new_id_q};
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`BSR_ASSERT_SAME(a_count_range, 1'b1, count_q <= bsr_pkg::CNT_W'(bsr_pkg::SLOTS))
	`BSR_ASSERT_NEXT(a_erase_shrinks, state_q == S_ERASE, count_q == $past(count_q) - 1'b1)
	`BSR_ASSERT_SAME(a_idle_fits, state_q == S_IDLE, used_q <= budget_q)
	`BSR_ASSERT_SAME(a_ok_status, m_tvalid && m_tuser[0], m_tuser[3:1] == bsr_pkg::ST_OK)
endmodule

### tb/sv/budgeted_snapshot_retention_tb.sv
// Testbench for the snapshot retention table: scoreboard class with a table predictor.
module budgeted_snapshot_retention_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Expected result of one operation
	typedef struct packed {
		logic        ok;
		logic [2:0]  status;
		logic [31:0] new_id;
		logic [4:0]  evicted;
		logic [31:0] used;
	} answer_t;

	// Predicts the table and keeps the answers still owed by the block
	class retention_board;
		logic        live_kind[$];
		logic [31:0] live_size[$];
		logic [31:0] live_id[$];
		logic [31:0] in_use;
		logic [31:0] budget;
		logic [31:0] next_id;
		answer_t     owed[$];
		int          errors;

		function new();
			in_use = 0;
			budget = 0;
			next_id = 1;
			errors = 0;
		endfunction

		function int oldest_auto();
			foreach (live_kind[i])
				if (live_kind[i] == 1'b0)
					return i;
			return -1;
		endfunction

		function void erase(int at);
			in_use = in_use - live_size[at];
			live_kind.delete(at);
			live_size.delete(at);
			live_id.delete(at);
		endfunction

		function bit evict(bit auto_only);
			int at;
			at = oldest_auto();
			if (at < 0) begin
				if (auto_only || live_kind.size() == 0)
					return 0;
				at = 0;
			end
			erase(at);
			return 1;
		endfunction

		// Note an accepted operation and queue its answer
		function void note_op(bsr_pkg::op_t op, logic kind, logic [31:0] bytes,
				logic [31:0] nb, logic [31:0] tgt);
			answer_t a;
			logic [63:0] reclaim;
			int ev;
			bit found;
			bit room;
			a = '0;
			ev = 0;
			case (op)
				bsr_pkg::OP_CAPTURE: begin
					if (bytes > budget) begin
						a.status = bsr_pkg::ST_TOO_LARGE;
					end else begin
						reclaim = 0;
						foreach (live_kind[i])
							if (!live_kind[i])
								reclaim += live_size[i];
						if (!kind && ({32'd0, in_use} + bytes - reclaim > budget)) begin
							a.status = bsr_pkg::ST_CKPT_KEPT;
						end else begin
							while ({32'd0, in_use} + bytes > budget) begin
								if (!evict(!kind))
									break;
								ev++;
							end
							if ({32'd0, in_use} + bytes > budget) begin
								a.status = bsr_pkg::ST_CKPT_KEPT;
							end else begin
								// A full table gives up one more entry by the same rule
								room = 1;
								if (live_kind.size() >= bsr_pkg::SLOTS) begin
									if (evict(!kind))
										ev++;
									else
										room = 0;
								end
								if (!room) begin
									a.status = bsr_pkg::ST_FULL;
								end else begin
									live_kind.insert(live_kind.size(), kind);
									live_size.insert(live_size.size(), bytes);
									live_id.insert(live_id.size(), next_id);
									in_use = in_use + bytes;
									a.new_id = next_id;
									next_id = (next_id == 32'hFFFF_FFFF) ? 32'd1 : next_id + 1;
									a.ok = 1'b1;
								end
							end
						end
					end
				end
				bsr_pkg::OP_BUDGET: begin
					budget = nb;
					while (in_use > budget) begin
						if (!evict(0))
							break;
						ev++;
					end
				end
				bsr_pkg::OP_REMOVE: begin
					found = 0;
					for (int i = 0; i < live_id.size(); i++) begin
						if (live_id[i] == tgt) begin
							erase(i);
							found = 1;
							break;
						end
					end
					a.ok = found;
					a.status = found ? bsr_pkg::ST_OK : bsr_pkg::ST_NOT_FOUND;
				end
				default: begin
					live_kind.delete();
					live_size.delete();
					live_id.delete();
					in_use = 0;
				end
			endcase
			a.evicted = (ev > 31) ? 5'd31 : ev[4:0];
			a.used = in_use;
			owed.push_back(a);
		endfunction

		// Compare one result with the oldest answer still owed
		function void check_result(answer_t got);
			answer_t e;
			if (owed.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
				return;
			end
			e = owed.pop_front();
			if (got.ok !== e.ok)
				$display("%0t: ok expected %0d actual %0d", $time, e.ok, got.ok);
			if (got.status !== e.status)
				$display("%0t: status expected %0d actual %0d", $time, e.status, got.status);
			if (got.new_id !== e.new_id)
				$display("%0t: new_id expected %0d actual %0d", $time, e.new_id, got.new_id);
			if (got.evicted !== e.evicted)
				$display("%0t: evicted expected %0d actual %0d", $time, e.evicted,
					got.evicted);
			if (got.used !== e.used)
				$display("%0t: used expected %0d actual %0d", $time, e.used, got.used);
			if (got !== e)
				errors++;
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [95:0] s_tdata;
	logic [2:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;
	logic [3:0]  m_tuser;

	retention_board board;
	bit          stim_done;
	bit          hold_rx;
	longint      cycles;

	budgeted_snapshot_retention u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 80);
	endfunction

	// Present one operation and wait for its transfer
	task automatic send_op(bsr_pkg::op_t op, logic kind, logic [31:0] bytes, logic [31:0] nb,
			logic [31:0] tgt);
		s_tvalid <= 1'b1;
		s_tuser <= {kind, op};
		s_tdata <= {tgt, nb, bytes};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		board.note_op(op, kind, bytes, nb, tgt);
	endtask

	task automatic idle_tx(int n);
		if (n > 0) begin
			s_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Random 32-bit size, mostly small, sometimes at the extremes
	function automatic logic [31:0] rnd_size(logic [31:0] bud);
		int r;
		logic [63:0] v;
		r = $urandom_range(0, 19);
		if (r == 0) return $urandom;
		if (r == 1) return 32'hFFFF_FFFF;
		if (r == 2) return 0;
		if (bud == 0) return $urandom_range(0, 3);
		v = {32'd0, $urandom_range(0, (bud > 400) ? 400 : bud)};
		if (bud > 32'h1000_0000 && r < 6)
			v = v + ({32'd0, $urandom} % ({32'd0, bud} + 64'd1));
		return v[31:0];
	endfunction

	task automatic random_op();
		int r;
		logic [31:0] t;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			send_op(bsr_pkg::OP_CAPTURE, 1'($urandom_range(0, 1)), rnd_size(board.budget),
				$urandom, $urandom);
		end else if (r < 72) begin
			case ($urandom_range(0, 5))
				0: t = 0;
				1: t = 32'hFFFF_FFFF;
				2: t = $urandom;
				default: t = $urandom_range(50, 2000);
			endcase
			send_op(bsr_pkg::OP_BUDGET, 1'($urandom_range(0, 1)), $urandom, t, $urandom);
		end else if (r < 95) begin
			if (board.live_id.size() > 0 && $urandom_range(0, 3) != 0)
				t = board.live_id[$urandom_range(0, board.live_id.size() - 1)];
			else
				t = $urandom;
			send_op(bsr_pkg::OP_REMOVE, 1'($urandom_range(0, 1)), $urandom, $urandom, t);
		end else begin
			send_op(bsr_pkg::OP_CLEAR, 1'($urandom_range(0, 1)), $urandom, $urandom,
				$urandom);
		end
	endtask

	// Stimulus
	initial begin
		int i;
		board = new();
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		s_tuser = '0;
		stim_done = 0;
		hold_rx = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// Directed: zero budget, extremes, each status
		send_op(bsr_pkg::OP_CAPTURE, 1'b0, 32'd0, 0, 0);
		send_op(bsr_pkg::OP_CAPTURE, 1'b1, 32'd1, 0, 0);
		send_op(bsr_pkg::OP_BUDGET, 1'b0, 0, 32'hFFFF_FFFF, 0);
		send_op(bsr_pkg::OP_CAPTURE, 1'b1, 32'hFFFF_FFFF, 0, 0);
		send_op(bsr_pkg::OP_CAPTURE, 1'b0, 32'd5, 0, 0);
		send_op(bsr_pkg::OP_CAPTURE, 1'b1, 32'd5, 0, 0);
		send_op(bsr_pkg::OP_REMOVE, 1'b0, 0, 0, 32'd0);
		send_op(bsr_pkg::OP_REMOVE, 1'b0, 0, 0, 32'd1);
		send_op(bsr_pkg::OP_REMOVE, 1'b0, 0, 0, 32'd3);
		send_op(bsr_pkg::OP_BUDGET, 1'b0, 0, 32'd100, 0);
		send_op(bsr_pkg::OP_CAPTURE, 1'b1, 32'd60, 0, 0);
		send_op(bsr_pkg::OP_CAPTURE, 1'b0, 32'd50, 0, 0);
		send_op(bsr_pkg::OP_CAPTURE, 1'b0, 32'd10, 0, 0);
		send_op(bsr_pkg::OP_CAPTURE, 1'b1, 32'd90, 0, 0);
		send_op(bsr_pkg::OP_CLEAR, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		// Fill the table with checkpoints, then an automatic capture finds it full
		for (i = 0; i < bsr_pkg::SLOTS; i++)
			send_op(bsr_pkg::OP_CAPTURE, 1'b1, 32'd1, 0, 0);
		send_op(bsr_pkg::OP_CAPTURE, 1'b0, 32'd1, 0, 0);
		send_op(bsr_pkg::OP_CAPTURE, 1'b1, 32'd1, 0, 0);
		// Many evictions in one budget change
		send_op(bsr_pkg::OP_BUDGET, 1'b0, 0, 32'd0, 0);
		idle_tx(0);
		// Sender pauses until every result has come
		s_tvalid <= 1'b0;
		while (board.owed.size() != 0)
			@(posedge clk);
		// Receiver holds off while the sender keeps offering
		hold_rx <= 1'b1;
		for (i = 0; i < 1900; i++) begin
			if (i == 20)
				hold_rx <= 1'b0;
			random_op();
			if (i > 40 && i % 3 == 0)
				idle_tx(gap_len());
		end
		s_tvalid <= 1'b0;
		stim_done <= 1'b1;
	end

	// Receiver with random stalls and long hold-offs while hold_rx is set
	initial begin
		int n;
		m_tready = 0;
		@(posedge arst_n);
		forever begin
			if (hold_rx) begin
				m_tready <= 1'b0;
				repeat (400) @(posedge clk);
			end
			n = gap_len();
			if (n > 0) begin
				m_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
		end
	end

	// Result monitor
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_result({m_tuser[0], m_tuser[3:1], m_tdata[31:0], m_tdata[36:32],
				m_tdata[68:37]});
	end

	// Drain, timeout and final verdict
	initial begin
		cycles = 0;
		@(posedge arst_n);
		while (!(stim_done && board.owed.size() == 0)) begin
			@(posedge clk);
			cycles++;
			if (cycles > 3000000) begin
				$display("budgeted_snapshot_retention test failed");
				$finish;
			end
		end
		repeat (200) @(posedge clk);
		if (board.errors == 0 && board.owed.size() == 0)
			$display("budgeted_snapshot_retention test passed");
		else
			$display("budgeted_snapshot_retention test failed");
		$finish;
	end
endmodule
